@@ hw/rtl/aar_pkg.sv @@
// Shared types, constants and the arctangent table for the axis-angle rotation matrix block.
// No dependencies.
`default_nettype none
package aar_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_RUN    = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;
	localparam int SQRT_CELLS    = 32;
	localparam int DIV_CELLS     = 31;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;

	// State handed from cell to cell along the chain
	typedef struct packed {
		logic                   vld;
		logic                   zero;
		logic signed [15:0]     ang;
		logic signed [31:0]     ox;
		logic signed [31:0]     oy;
		logic signed [31:0]     oz;
		logic [2:0]             neg;
		logic [2:0][15:0]       mag;
		logic [31:0]            rad;
		logic [32:0]            srem;
		logic [31:0]            root;
		logic [2:0][31:0]       drem;
		logic [30:0]            nlo;
		logic [2:0][30:0]       quo;
		logic signed [33:0]     cx;
		logic signed [33:0]     cy;
		logic signed [33:0]     cz;
	} work_t;

	// atan(2^-i) in Q2.30, truncated
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000007;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/aar_sqrt_cell.sv @@
// One cell of the square-root chain: one root bit per cycle.
// Depends on aar_pkg.
`default_nettype none
module aar_sqrt_cell import aar_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  work_t cin,
	output work_t cout
);

	logic [34:0] cur;
	logic [34:0] trial;
	work_t       nxt;

	always_comb begin
		nxt   = cin;
		cur   = {cin.srem, cin.rad[31:30]};
		trial = {1'b0, cin.root, 2'b01};
		if (cur >= trial) begin
			nxt.srem = 33'(cur - trial);
			nxt.root = {cin.root[30:0], 1'b1};
		end else begin
			nxt.srem = cur[32:0];
			nxt.root = {cin.root[30:0], 1'b0};
		end
		nxt.rad = {cin.rad[29:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout <= '0;
		end else begin
			cout <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/aar_div_cell.sv @@
// One cell of the normalising divider chain: one quotient bit per cycle for all three components.
// Depends on aar_pkg.
`default_nettype none
module aar_div_cell import aar_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  work_t cin,
	output work_t cout
);

	logic [32:0] cur [3];
	work_t       nxt;

	always_comb begin
		nxt = cin;
		for (int k = 0; k < 3; k++) begin
			cur[k] = {cin.drem[k], cin.nlo[30]};
			if (cur[k] >= {1'b0, cin.root}) begin
				nxt.drem[k] = 32'(cur[k] - {1'b0, cin.root});
				nxt.quo[k]  = {cin.quo[k][29:0], 1'b1};
			end else begin
				nxt.drem[k] = cur[k][31:0];
				nxt.quo[k]  = {cin.quo[k][29:0], 1'b0};
			end
		end
		nxt.nlo = {cin.nlo[29:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout <= '0;
		end else begin
			cout <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/aar_cordic_cell.sv @@
// One rotation-mode CORDIC stage; stage is tied to a constant at the instance.
// Depends on aar_pkg.
`default_nettype none
module aar_cordic_cell import aar_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [4:0] stage,
	input  work_t      cin,
	output work_t      cout
);

	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [33:0] at;
	work_t              nxt;

	always_comb begin
		nxt = cin;
		dx  = cin.cy >>> stage;
		dy  = cin.cx >>> stage;
		at  = signed'({2'b00, atan_q30(stage)});
		if (!cin.cz[33]) begin
			nxt.cx = cin.cx - dx;
			nxt.cy = cin.cy + dy;
			nxt.cz = cin.cz - at;
		end else begin
			nxt.cx = cin.cx + dx;
			nxt.cy = cin.cy - dy;
			nxt.cz = cin.cz + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout <= '0;
		end else begin
			cout <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/aar_matrix.sv @@
// Quaternion and matrix products, rounding to Q16.16, and the four-row result sequencer.
// Depends on aar_pkg.
`default_nettype none
module aar_matrix import aar_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  work_t              cin,
	output logic               done,
	output logic [1:0]         row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic               last_row,
	output logic               axis_zero
);

	localparam logic signed [79:0] ONE60 = 80'sd1 <<< 60;
	localparam logic signed [65:0] HALF29 = 66'sd1 <<< 29;
	localparam logic signed [31:0] ONE16 = 32'sd65536;

	function automatic logic signed [31:0] to_q16(input logic signed [79:0] v);
		logic signed [79:0] t;
		t = v + (80'sd1 <<< 43);
		return t[75:44];
	endfunction

	// stage 1: unit axis
	logic               v_s1, z_s1;
	logic signed [31:0] u_s1 [3];
	logic signed [33:0] cx_s1, cy_s1;
	logic signed [31:0] ox_s1, oy_s1, oz_s1;
	// stage 2: u * sin
	logic               v_s2, z_s2;
	logic signed [65:0] p_s2 [3];
	logic signed [33:0] w_s2;
	logic signed [31:0] ox_s2, oy_s2, oz_s2;
	// stage 3: quaternion
	logic               v_s3, z_s3;
	logic signed [33:0] q_s3 [4];
	logic signed [31:0] ox_s3, oy_s3, oz_s3;
	// stage 4: quaternion products xx yy zz xy xz yz wx wy wz
	logic               v_s4, z_s4;
	logic signed [67:0] m_s4 [9];
	logic signed [31:0] ox_s4, oy_s4, oz_s4;
	// held matrix
	logic signed [31:0] r_q [9];
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic               zero_q;
	logic               act_q;
	logic [1:0]         cnt_q;

	logic [30:0]        qc [3];
	logic signed [79:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
	logic signed [31:0] ent [9];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qc[k] = (cin.quo[k] > 31'h40000000) ? 31'h40000000 : cin.quo[k];
		end
		xx = 80'(m_s4[0]); yy = 80'(m_s4[1]); zz = 80'(m_s4[2]);
		xy = 80'(m_s4[3]); xz = 80'(m_s4[4]); yz = 80'(m_s4[5]);
		wx = 80'(m_s4[6]); wy = 80'(m_s4[7]); wz = 80'(m_s4[8]);
		ent[0] = to_q16(ONE60 - 2 * (yy + zz));
		ent[1] = to_q16(2 * (xy + wz));
		ent[2] = to_q16(2 * (xz - wy));
		ent[3] = to_q16(2 * (xy - wz));
		ent[4] = to_q16(ONE60 - 2 * (xx + zz));
		ent[5] = to_q16(2 * (yz + wx));
		ent[6] = to_q16(2 * (xz + wy));
		ent[7] = to_q16(2 * (yz - wx));
		ent[8] = to_q16(ONE60 - 2 * (xx + yy));
		if (z_s4) begin
			for (int k = 0; k < 9; k++) begin
				ent[k] = ((k == 0) || (k == 4) || (k == 8)) ? ONE16 : 32'sd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			act_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			v_s1 <= cin.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				act_q <= 1'b1;
				cnt_q <= 2'd0;
			end else if (act_q) begin
				if (cnt_q == 2'd3) begin
					act_q <= 1'b0;
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		z_s1  <= cin.zero;
		for (int k = 0; k < 3; k++) begin
			u_s1[k] <= cin.neg[k] ? -signed'({1'b0, qc[k]}) : signed'({1'b0, qc[k]});
		end
		cx_s1 <= cin.cx;
		cy_s1 <= cin.cy;
		ox_s1 <= cin.ox; oy_s1 <= cin.oy; oz_s1 <= cin.oz;

		z_s2 <= z_s1;
		for (int k = 0; k < 3; k++) begin
			p_s2[k] <= u_s1[k] * cy_s1;
		end
		w_s2  <= cx_s1;
		ox_s2 <= ox_s1; oy_s2 <= oy_s1; oz_s2 <= oz_s1;

		z_s3 <= z_s2;
		for (int k = 0; k < 3; k++) begin
			q_s3[k] <= 34'((p_s2[k] + HALF29) >>> 30);
		end
		q_s3[3] <= w_s2;
		ox_s3 <= ox_s2; oy_s3 <= oy_s2; oz_s3 <= oz_s2;

		z_s4 <= z_s3;
		m_s4[0] <= q_s3[0] * q_s3[0];
		m_s4[1] <= q_s3[1] * q_s3[1];
		m_s4[2] <= q_s3[2] * q_s3[2];
		m_s4[3] <= q_s3[0] * q_s3[1];
		m_s4[4] <= q_s3[0] * q_s3[2];
		m_s4[5] <= q_s3[1] * q_s3[2];
		m_s4[6] <= q_s3[3] * q_s3[0];
		m_s4[7] <= q_s3[3] * q_s3[1];
		m_s4[8] <= q_s3[3] * q_s3[2];
		ox_s4 <= ox_s3; oy_s4 <= oy_s3; oz_s4 <= oz_s3;

		// held while the four result rows are sent
		if (v_s4) begin
			r_q    <= ent;
			ox_q   <= ox_s4; oy_q <= oy_s4; oz_q <= oz_s4;
			zero_q <= z_s4;
		end
	end

	always_comb begin
		done      = act_q;
		row_index = cnt_q;
		last_row  = (cnt_q == 2'd3);
		axis_zero = zero_q;
		unique case (cnt_q)
			2'd0: begin col0 = r_q[0]; col1 = r_q[1]; col2 = r_q[2]; col3 = '0; end
			2'd1: begin col0 = r_q[3]; col1 = r_q[4]; col2 = r_q[5]; col3 = '0; end
			2'd2: begin col0 = r_q[6]; col1 = r_q[7]; col2 = r_q[8]; col3 = '0; end
			2'd3: begin col0 = ox_q;   col1 = oy_q;   col2 = oz_q;   col3 = ONE16; end
			default: begin col0 = '0; col1 = '0; col2 = '0; col3 = '0; end
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/axis_angle_rotation_matrix.sv @@
// Top level: axis-angle to 4x4 transform, built as chains of square-root, divider and CORDIC cells.
// Depends on aar_pkg, aar_sqrt_cell, aar_div_cell, aar_cordic_cell, aar_matrix.
//
//  channel  handshake          payload
//  item in  start / busy       axis_x..z, angle, offset_x..z
//  rows out done               row_index, col0..col3, last_row, axis_zero
//
// After an accept, busy stays high so that the four row results of one item can share the
// one output channel; no new item is taken while busy. Items overlap in the cell chains.
// From the accepting edge to row 0 an item passes the input register, the square-root,
// divider and CORDIC cell chains, the matrix stages and the held result registers.
// Reset clears all valid state; no result is ever stalled.
`default_nettype none
module axis_angle_rotation_matrix import aar_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [15:0] angle,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] offset_z,
	output logic               done,
	output logic [1:0]         row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic               last_row,
	output logic               axis_zero
);

	logic [1:0]         gap_q;
	logic               accept;
	logic               v_s1;
	logic [30:0]        sq_s1 [3];
	logic [2:0]         neg_s1;
	logic [2:0][15:0]   mag_s1;
	logic signed [15:0] ang_s1;
	logic signed [31:0] ox_s1, oy_s1, oz_s1;

	logic signed [31:0] px, py, pz;
	logic signed [15:0] ang_sat;
	logic [31:0]        len2;

	work_t sq_w [SQRT_CELLS+1];
	work_t dv_w [DIV_CELLS+1];
	work_t cr_w [CORDIC_RUN+1];

	assign accept = start && !busy;
	assign busy   = (gap_q != 2'd0);

	always_comb begin
		px = axis_x * axis_x;
		py = axis_y * axis_y;
		pz = axis_z * axis_z;
		if (angle > ANGLE_LIMIT) begin
			ang_sat = ANGLE_LIMIT;
		end else if (angle < -ANGLE_LIMIT) begin
			ang_sat = -ANGLE_LIMIT;
		end else begin
			ang_sat = angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				gap_q <= 2'd3;
			end else if (gap_q != 2'd0) begin
				gap_q <= gap_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_s1[0]  <= px[30:0];
		sq_s1[1]  <= py[30:0];
		sq_s1[2]  <= pz[30:0];
		neg_s1    <= {axis_z[15], axis_y[15], axis_x[15]};
		mag_s1[0] <= axis_x[15] ? 16'(-axis_x) : axis_x;
		mag_s1[1] <= axis_y[15] ? 16'(-axis_y) : axis_y;
		mag_s1[2] <= axis_z[15] ? 16'(-axis_z) : axis_z;
		ang_s1    <= ang_sat;
		ox_s1     <= offset_x;
		oy_s1     <= offset_y;
		oz_s1     <= offset_z;
	end

	// chain heads
	always_comb begin
		len2 = 32'(sq_s1[0]) + 32'(sq_s1[1]) + 32'(sq_s1[2]);
		sq_w[0]      = '0;
		sq_w[0].vld  = v_s1;
		sq_w[0].zero = (len2 == 32'd0);
		sq_w[0].ang  = ang_s1;
		sq_w[0].ox   = ox_s1;
		sq_w[0].oy   = oy_s1;
		sq_w[0].oz   = oz_s1;
		sq_w[0].neg  = neg_s1;
		sq_w[0].mag  = mag_s1;
		sq_w[0].rad  = len2;

		dv_w[0] = sq_w[SQRT_CELLS];
		for (int k = 0; k < 3; k++) begin
			dv_w[0].drem[k] = {1'b0, sq_w[SQRT_CELLS].mag[k], 15'd0};
			dv_w[0].quo[k]  = '0;
		end
		dv_w[0].nlo = sq_w[SQRT_CELLS].root[31:1];

		cr_w[0]    = dv_w[DIV_CELLS];
		cr_w[0].cx = CORDIC_GAIN;
		cr_w[0].cy = '0;
		cr_w[0].cz = {{2{dv_w[DIV_CELLS].ang[15]}}, dv_w[DIV_CELLS].ang, 16'd0};
	end

	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
		aar_sqrt_cell u_cell (.clk(clk), .arst_n(arst_n), .cin(sq_w[i]), .cout(sq_w[i+1]));
	end

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		aar_div_cell u_cell (.clk(clk), .arst_n(arst_n), .cin(dv_w[i]), .cout(dv_w[i+1]));
	end

	for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_cordic
		aar_cordic_cell u_cell (
			.clk(clk), .arst_n(arst_n), .stage(5'(i)), .cin(cr_w[i]), .cout(cr_w[i+1])
		);
	end

	aar_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cin       (cr_w[CORDIC_RUN]),
		.done      (done),
		.row_index (row_index),
		.col0      (col0),
		.col1      (col1),
		.col2      (col2),
		.col3      (col3),
		.last_row  (last_row),
		.axis_zero (axis_zero)
	);

endmodule
`default_nettype wire

@@ hw/rtl/aar_checker.sv @@
// Port-level checks on the rotation matrix block, bound to the top level.
// Depends on axis_angle_rotation_matrix.
`default_nettype none
module aar_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         row_index,
	input logic signed [31:0] col3,
	input logic               last_row,
	input logic               axis_zero
);

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_row == (row_index == 2'd3)))
		else $error("last_row does not match row 3");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && row_index != 2'd3) |=> (done && row_index == $past(row_index) + 2'd1))
		else $error("rows of an item not consecutive");

	a_zero_held: assert property (@(posedge clk) disable iff (!arst_n)
		(done && row_index != 2'd3) |=> (axis_zero == $past(axis_zero)))
		else $error("axis_zero changed within an item");

	a_col3: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((row_index == 2'd3) ? (col3 == 32'sd65536) : (col3 == 32'sd0)))
		else $error("column 3 wrong");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

endmodule

bind axis_angle_rotation_matrix aar_checker u_aar_checker (.*);
`default_nettype wire

@@ tb/axis_angle_rotation_matrix_tb.sv @@
// Testbench for axis_angle_rotation_matrix: directed and random axis/angle/offset items,
// each predicted in fixed point and checked row by row. Depends on aar_pkg and the RTL.
`default_nettype none

module axis_angle_rotation_matrix_tb import aar_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  row;
		logic [31:0] c0, c1, c2, c3;
		logic        last, zero;
	} row_t;

	class row_scoreboard;
		row_t pending[$];
		int   mismatches;
		int   rows_checked;

		static function longint to_q16(longint v60);
			return (v60 + (longint'(1) <<< 43)) >>> 44;
		endfunction

		static function longint unit_part(longint a, longint unsigned s);
			longint unsigned mag, q;
			mag = (a < 0) ? -a : a;
			q = ((mag << 46) + (s >> 1)) / s;
			if (q > (64'd1 << 30))
				q = 64'd1 << 30;
			return (a < 0) ? -longint'(q) : longint'(q);
		endfunction

		static function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		function void push_row(int r, longint a, longint b, longint c, longint d, bit z);
			row_t e;
			e.row = r[1:0];
			e.c0 = a[31:0];
			e.c1 = b[31:0];
			e.c2 = c[31:0];
			e.c3 = d[31:0];
			e.last = (r == 3);
			e.zero = z;
			pending.push_back(e);
		endfunction

		// Work out the four rows of one accepted item
		function void note_item(logic signed [15:0] ax, ay, az, ang,
				logic signed [31:0] ox, oy, oz);
			longint m[3][3];
			longint x, y, z, a, len2, cx, cy, cz, dx, dy, qx, qy, qz, qw, ux, uy, uz, one60;
			longint unsigned s;
			bit zero;
			x = ax; y = ay; z = az; a = ang;
			len2 = x * x + y * y + z * z;
			zero = (len2 == 0);
			if (zero) begin
				foreach (m[i, j])
					m[i][j] = (i == j) ? 65536 : 0;
			end else begin
				s = int_sqrt(longint'(len2) << 32);
				ux = unit_part(x, s);
				uy = unit_part(y, s);
				uz = unit_part(z, s);
				if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
				if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
				cx = CORDIC_GAIN;
				cy = 0;
				cz = a * 65536;
				for (int i = 0; i < CORDIC_RUN; i++) begin
					dx = cy >>> i;
					dy = cx >>> i;
					if (cz >= 0) begin
						cx -= dx; cy += dy; cz -= longint'(atan_q30(i[4:0]));
					end else begin
						cx += dx; cy -= dy; cz += longint'(atan_q30(i[4:0]));
					end
				end
				qx = (ux * cy + (longint'(1) <<< 29)) >>> 30;
				qy = (uy * cy + (longint'(1) <<< 29)) >>> 30;
				qz = (uz * cy + (longint'(1) <<< 29)) >>> 30;
				qw = cx;
				one60 = longint'(1) <<< 60;
				m[0][0] = to_q16(one60 - 2 * (qy * qy + qz * qz));
				m[0][1] = to_q16(2 * (qx * qy + qw * qz));
				m[0][2] = to_q16(2 * (qx * qz - qw * qy));
				m[1][0] = to_q16(2 * (qx * qy - qw * qz));
				m[1][1] = to_q16(one60 - 2 * (qx * qx + qz * qz));
				m[1][2] = to_q16(2 * (qy * qz + qw * qx));
				m[2][0] = to_q16(2 * (qx * qz + qw * qy));
				m[2][1] = to_q16(2 * (qy * qz - qw * qx));
				m[2][2] = to_q16(one60 - 2 * (qx * qx + qy * qy));
			end
			for (int r = 0; r < 3; r++)
				push_row(r, m[r][0], m[r][1], m[r][2], 0, zero);
			push_row(3, ox, oy, oz, 65536, zero);
		endfunction

		function void check_row(row_t got);
			row_t e;
			rows_checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected row %0d with nothing pending", got.row);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("row mismatch: exp row=%0d %h %h %h %h last=%b zero=%b",
						e.row, e.c0, e.c1, e.c2, e.c3, e.last, e.zero);
					$display("              got row=%0d %h %h %h %h last=%b zero=%b",
						got.row, got.c0, got.c1, got.c2, got.c3, got.last, got.zero);
				end
			end
		endfunction
	endclass

	localparam int LATENCY    = 2 + SQRT_CELLS + DIV_CELLS + CORDIC_RUN + 5 + 8;
	localparam int CYCLE_CAP  = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0, angle = '0;
	logic signed [31:0] offset_x = '0, offset_y = '0, offset_z = '0;
	logic               done;
	logic [1:0]         row_index;
	logic signed [31:0] col0, col1, col2, col3;
	logic               last_row, axis_zero;

	row_scoreboard sb = new();
	int  send_idle_pct = 0;
	int  items_sent = 0;
	int  cycles = 0;

	axis_angle_rotation_matrix dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		row_t r;
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
		if (arst_n && done) begin
			r.row = row_index; r.c0 = col0; r.c1 = col1; r.c2 = col2; r.c3 = col3;
			r.last = last_row; r.zero = axis_zero;
			sb.check_row(r);
		end
	end

	// Present one item, hold it until accepted, then optionally idle
	task automatic send_item(logic signed [15:0] ax, ay, az, ang,
			logic signed [31:0] ox, oy, oz);
		axis_x <= ax; axis_y <= ay; axis_z <= az; angle <= ang;
		offset_x <= ox; offset_y <= oy; offset_z <= oz;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		sb.note_item(ax, ay, az, ang, ox, oy, oz);
		items_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] rand_angle();
		return $signed(16'($urandom_range(2 * 25736 + 40))) - 16'sd25756;
	endfunction

	task automatic random_item();
		logic signed [15:0] ax, ay, az;
		int sel;
		ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
		sel = $urandom_range(9);
		if (sel == 0) begin
			ax = '0; ay = '0; az = '0;
		end else if (sel < 3) begin
			ax = $signed(16'($urandom_range(0, 6))) - 16'sd3;
			ay = $signed(16'($urandom_range(0, 6))) - 16'sd3;
		end
		send_item(ax, ay, az, rand_angle(), $urandom, $urandom, $urandom);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero axis, axis extremes, angle limits and beyond, offset extremes
		send_item(0, 0, 0, 0, 0, 0, 0);
		send_item(0, 0, 0, 16'sd25736, 32'sh7FFFFFFF, 32'sh80000000, -1);
		send_item(16'sd16384, 0, 0, 16'sd12868, 1, 2, 3);
		send_item(0, 16'sd16384, 0, -16'sd12868, 0, 0, 0);
		send_item(0, 0, 16'sd16384, 16'sd25736, 0, 0, 0);
		send_item(0, 0, 16'sd16384, -16'sd25736, 0, 0, 0);
		send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0);
		send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000,
			32'sh80000000, 32'sh80000000);
		send_item(16'sh8000, 0, 0, 16'sd1, 0, 0, 0);
		send_item(1, 0, 0, -16'sd1, 0, 0, 0);
		send_item(-1, -1, 1, 16'sd100, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_item(16'sh7FFF, 0, 0, 16'sd25737, 0, 0, 0);
		send_item(0, 16'sh8000, 0, -16'sd25737, 0, 0, 0);
		send_item(16'sh5555, 16'shAAAA, 16'sh1234, 16'sd5000, 32'h55555555,
			32'hAAAAAAAA, 32'h12345678);

		// Random phases: back to back, then sender idling heavily, lightly and heavily again
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? 65 : (ph == 2 ? 9 : 0);
			repeat (42)
				random_item();
		end
		start <= 1'b0;

		while (sb.pending.size() != 0 && cycles < CYCLE_CAP)
			@(posedge clk);
		repeat (LATENCY)
			@(posedge clk);

		$display("%0d items sent, %0d rows checked", items_sent, sb.rows_checked);
		$display("zero axes, angle saturation and offset extremes included");
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else begin
			$display("%0d mismatches, %0d rows missing", sb.mismatches, sb.pending.size());
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

`default_nettype wire
